// ===== rtl/sparse_3d_block_owner_map_core_defines.svh =====
// assertion macros for the block owner map core
`ifndef SPARSE_3D_BLOCK_OWNER_MAP_CORE_DEFINES_SVH
`define SPARSE_3D_BLOCK_OWNER_MAP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SBOM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbom assertion failed");
`define SBOM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbom assertion failed");
`else
`define SBOM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBOM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sbom_pkg.sv =====
// shared types and constants of the block owner map
package sbom_pkg;

  localparam int GRID_QB   = 12;
  localparam int LAYER_QB  = 8;
  localparam int GRID_W    = 13;
  localparam int LAYER_W   = 9;
  localparam int MAX_GRID   = 4096;
  localparam int MAX_LAYERS = 256;

  typedef enum logic [2:0] {
    REG_TOTAL_ROWS  = 3'd0,
    REG_TOTAL_COLS  = 3'd1,
    REG_GRID_ROWS   = 3'd2,
    REG_GRID_COLS   = 3'd3,
    REG_LAYER_COUNT = 3'd4,
    REG_SPLIT_COLS  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_MPER,
    S_MUL_MBASE,
    S_DIV_NPER,
    S_MUL_NBASE,
    S_DIV_SHN,
    S_DIV_SHL,
    S_MUL_LBN,
    S_MUL_LBL
  } cfg_state_t;

  typedef struct packed {
    logic                busy;
    logic                split_cols;
    logic [GRID_QB-1:0]  qmax_row;
    logic [GRID_QB-1:0]  qmax_col;
    logic [LAYER_QB-1:0] qmax_layer;
  } cfg_ctrl_t;

endpackage

// ===== rtl/sbom_cfg.sv =====
// configuration registers and sequential setup of block sizes and layer shares
module sbom_cfg #(
  parameter int IW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_wdata,
  output sbom_pkg::cfg_ctrl_t   ctrl,
  output logic [IW-1:0]         mper,
  output logic [IW-1:0]         mbase,
  output logic [IW-1:0]         nper,
  output logic [IW-1:0]         nbase,
  output logic [IW-1:0]         share_n,
  output logic [IW-1:0]         share_l,
  output logic [IW-1:0]         lbase_n,
  output logic [IW-1:0]         lbase_l
);
  import sbom_pkg::*;

  localparam int CW = $clog2(IW + 1);
  localparam int XW = ((IW > GRID_W) ? IW : GRID_W) + 1;

  logic [31:0]        tot_rows_r, tot_cols_r;
  logic [GRID_W-1:0]  grid_rows_r, grid_cols_r;
  logic [LAYER_W-1:0] layers_r;
  logic               split_r;

  logic [GRID_W-1:0]  gr_eff, gc_eff;
  logic [LAYER_W-1:0] nl_eff;
  logic [IW-1:0]      tr, tc;

  cfg_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] dq_r, rem_r;
  logic [IW-1:0] mper_r, mbase_r, nper_r, nbase_r, shn_r, shl_r, lbn_r, lbl_r;

  logic              is_div, div_done;
  logic [IW-1:0]     div_a;
  logic [GRID_W-1:0] div_b;
  logic [IW-1:0]     mul_a;
  logic [GRID_QB-1:0] mul_b;
  logic [IW+GRID_QB-1:0] prod;
  logic [IW:0]       sh;
  logic [XW-1:0]     sh_x, dvs_x, diff_x;
  logic              ge;
  logic [IW-1:0]     quot;
  logic [IW-1:0]     per_sel, base_sel, tot_sel;

  always_comb begin
    gr_eff = (grid_rows_r == '0) ? GRID_W'(1) :
             (grid_rows_r > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_rows_r;
    gc_eff = (grid_cols_r == '0) ? GRID_W'(1) :
             (grid_cols_r > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_cols_r;
    nl_eff = (layers_r == '0) ? LAYER_W'(1) :
             (layers_r > LAYER_W'(MAX_LAYERS)) ? LAYER_W'(MAX_LAYERS) : layers_r;
    tr = tot_rows_r[IW-1:0];
    tc = tot_cols_r[IW-1:0];
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_rows_r  <= 32'd1;
      tot_cols_r  <= 32'd1;
      grid_rows_r <= GRID_W'(1);
      grid_cols_r <= GRID_W'(1);
      layers_r    <= LAYER_W'(1);
      split_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TOTAL_ROWS:  tot_rows_r  <= cfg_wdata;
        REG_TOTAL_COLS:  tot_cols_r  <= cfg_wdata;
        REG_GRID_ROWS:   grid_rows_r <= cfg_wdata[GRID_W-1:0];
        REG_GRID_COLS:   grid_cols_r <= cfg_wdata[GRID_W-1:0];
        REG_LAYER_COUNT: layers_r    <= cfg_wdata[LAYER_W-1:0];
        REG_SPLIT_COLS:  split_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    per_sel  = split_r ? nper_r : mper_r;
    base_sel = split_r ? nbase_r : mbase_r;
    tot_sel  = split_r ? tc : tr;
  end

  // operand selection per setup step
  always_comb begin
    is_div = 1'b0;
    div_a  = '0;
    div_b  = '0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_DIV_MPER: begin
        is_div = 1'b1;
        div_a  = tr;
        div_b  = gr_eff;
      end
      S_DIV_NPER: begin
        is_div = 1'b1;
        div_a  = tc;
        div_b  = gc_eff;
      end
      S_DIV_SHN: begin
        is_div = 1'b1;
        div_a  = per_sel;
        div_b  = GRID_W'(nl_eff);
      end
      S_DIV_SHL: begin
        is_div = 1'b1;
        div_a  = tot_sel - base_sel;
        div_b  = GRID_W'(nl_eff);
      end
      S_MUL_MBASE: begin
        mul_a = mper_r;
        mul_b = GRID_QB'(gr_eff - GRID_W'(1));
      end
      S_MUL_NBASE: begin
        mul_a = nper_r;
        mul_b = GRID_QB'(gc_eff - GRID_W'(1));
      end
      S_MUL_LBN: begin
        mul_a = shn_r;
        mul_b = GRID_QB'(nl_eff - LAYER_W'(1));
      end
      S_MUL_LBL: begin
        mul_a = shl_r;
        mul_b = GRID_QB'(nl_eff - LAYER_W'(1));
      end
      default: ;
    endcase
  end

  assign div_done = is_div && (cnt_r == CW'(IW));
  assign prod     = {{GRID_QB{1'b0}}, mul_a} * {{IW{1'b0}}, mul_b};

  // one quotient bit per cycle, count zero loads the dividend
  always_comb begin
    sh     = {rem_r, dq_r[IW-1]};
    sh_x   = XW'(sh);
    dvs_x  = XW'(div_b);
    ge     = sh_x >= dvs_x;
    diff_x = sh_x - dvs_x;
    quot   = {dq_r[IW-2:0], ge};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      state_nxt = S_IDLE;
      S_DIV_MPER:  if (div_done) state_nxt = S_MUL_MBASE;
      S_MUL_MBASE: state_nxt = S_DIV_NPER;
      S_DIV_NPER:  if (div_done) state_nxt = S_MUL_NBASE;
      S_MUL_NBASE: state_nxt = S_DIV_SHN;
      S_DIV_SHN:   if (div_done) state_nxt = S_DIV_SHL;
      S_DIV_SHL:   if (div_done) state_nxt = S_MUL_LBN;
      S_MUL_LBN:   state_nxt = S_MUL_LBL;
      S_MUL_LBL:   state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DIV_MPER;
      cnt_r   <= '0;
    end else if (cfg_wr_en) begin
      state_r <= S_DIV_MPER;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (!is_div || div_done) ? '0 : cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (is_div) begin
      if (cnt_r == '0) begin
        dq_r  <= div_a;
        rem_r <= '0;
      end else begin
        dq_r  <= quot;
        rem_r <= ge ? diff_x[IW-1:0] : sh[IW-1:0];
      end
    end
    // the last quotient bit is resolved in the done cycle
    if (div_done) begin
      unique case (state_r)
        S_DIV_MPER: mper_r <= quot;
        S_DIV_NPER: nper_r <= quot;
        S_DIV_SHN:  shn_r  <= quot;
        S_DIV_SHL:  shl_r  <= quot;
        default: ;
      endcase
    end
    unique case (state_r)
      S_MUL_MBASE: mbase_r <= prod[IW-1:0];
      S_MUL_NBASE: nbase_r <= prod[IW-1:0];
      S_MUL_LBN:   lbn_r   <= prod[IW-1:0];
      S_MUL_LBL:   lbl_r   <= prod[IW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    ctrl.busy       = state_r != S_IDLE;
    ctrl.split_cols = split_r;
    ctrl.qmax_row   = GRID_QB'(gr_eff - GRID_W'(1));
    ctrl.qmax_col   = GRID_QB'(gc_eff - GRID_W'(1));
    ctrl.qmax_layer = LAYER_QB'(nl_eff - LAYER_W'(1));
  end

  assign mper    = mper_r;
  assign mbase   = mbase_r;
  assign nper    = nper_r;
  assign nbase   = nbase_r;
  assign share_n = shn_r;
  assign share_l = shl_r;
  assign lbase_n = lbn_r;
  assign lbase_l = lbl_r;

endmodule

// ===== rtl/sbom_grid_div.sv =====
// pipelined saturating divider that picks the grid row or column and its offset
module sbom_grid_div #(
  parameter int IW = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [IW-1:0]                dividend,
  input  logic [IW-1:0]                divisor,
  input  logic [sbom_pkg::GRID_QB-1:0] qmax,
  input  logic [IW-1:0]                base_last,
  output logic                         out_valid,
  output logic [sbom_pkg::GRID_QB-1:0] out_who,
  output logic [IW-1:0]                out_off,
  output logic                         out_last
);
  import sbom_pkg::*;

  localparam int QB = GRID_QB;
  localparam int NS = QB + 1;

  logic [NS-1:0] v_r;
  logic [IW-1:0] rem_r [NS];
  logic [IW-1:0] x_r   [NS];
  logic [IW-1:0] d_r   [NS];
  logic [QB-1:0] q_r   [NS];
  logic          sat_r [NS];
  logic          over;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // first stage flags a quotient of 2^QB or more, or a zero divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dividend;
      x_r[0]   <= dividend;
      d_r[0]   <= divisor;
      q_r[0]   <= '0;
      sat_r[0] <= (divisor == '0) ||
                  ({{QB{1'b0}}, dividend} >= {divisor, {QB{1'b0}}});
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int B = QB - k;
    logic [IW+QB-1:0] trial;
    logic             ge;
    always_comb begin
      trial = {{QB{1'b0}}, d_r[k-1]} << B;
      ge    = {{QB{1'b0}}, rem_r[k-1]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_r[k-1] - trial[IW-1:0] : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (ge ? (QB'(1) << B) : '0);
        x_r[k]   <= x_r[k-1];
        d_r[k]   <= d_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  always_comb begin
    over      = sat_r[NS-1] || (q_r[NS-1] > qmax);
    out_valid = v_r[NS-1];
    out_who   = over ? qmax : q_r[NS-1];
    out_off   = over ? x_r[NS-1] - base_last : rem_r[NS-1];
    out_last  = out_who == qmax;
  end

endmodule

// ===== rtl/sbom_layer_div.sv =====
// pipelined saturating divider that picks the layer and the offset inside it
module sbom_layer_div #(
  parameter int IW = 32,
  parameter int PW = 56
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [IW-1:0]                 dividend,
  input  logic [IW-1:0]                 divisor,
  input  logic [IW-1:0]                 base_last,
  input  logic [PW-1:0]                 in_pay,
  input  logic [sbom_pkg::LAYER_QB-1:0] qmax,
  output logic                          out_valid,
  output logic [sbom_pkg::LAYER_QB-1:0] out_who,
  output logic [IW-1:0]                 out_off,
  output logic [PW-1:0]                 out_pay
);
  import sbom_pkg::*;

  localparam int QB = LAYER_QB;
  localparam int NS = QB + 1;

  logic [NS-1:0] v_r;
  logic [IW-1:0] rem_r  [NS];
  logic [IW-1:0] x_r    [NS];
  logic [IW-1:0] d_r    [NS];
  logic [IW-1:0] base_r [NS];
  logic [PW-1:0] pay_r  [NS];
  logic [QB-1:0] q_r    [NS];
  logic          sat_r  [NS];
  logic          over;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= dividend;
      x_r[0]    <= dividend;
      d_r[0]    <= divisor;
      base_r[0] <= base_last;
      pay_r[0]  <= in_pay;
      q_r[0]    <= '0;
      sat_r[0]  <= (divisor == '0) ||
                   ({{QB{1'b0}}, dividend} >= {divisor, {QB{1'b0}}});
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int B = QB - k;
    logic [IW+QB-1:0] trial;
    logic             ge;
    always_comb begin
      trial = {{QB{1'b0}}, d_r[k-1]} << B;
      ge    = {{QB{1'b0}}, rem_r[k-1]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_r[k-1] - trial[IW-1:0] : rem_r[k-1];
        q_r[k]    <= q_r[k-1] | (ge ? (QB'(1) << B) : '0);
        x_r[k]    <= x_r[k-1];
        d_r[k]    <= d_r[k-1];
        base_r[k] <= base_r[k-1];
        pay_r[k]  <= pay_r[k-1];
        sat_r[k]  <= sat_r[k-1];
      end
    end
  end

  always_comb begin
    over      = sat_r[NS-1] || (q_r[NS-1] > qmax);
    out_valid = v_r[NS-1];
    out_who   = over ? qmax : q_r[NS-1];
    out_off   = over ? x_r[NS-1] - base_r[NS-1] : rem_r[NS-1];
    out_pay   = pay_r[NS-1];
  end

endmodule

// ===== rtl/sparse_3d_block_owner_map_core.sv =====
// Owner map for nonzeros of a matrix spread over a 3D process grid. One
// transaction in gives one transaction out, a new entry can be taken every
// cycle and results leave in order through 13 stages of the grid
// divider (saturation check plus one quotient bit each for 12 bits), one
// select stage, 9 stages of the layer divider and the output register. The
// whole pipeline advances only while the output register is empty or being
// taken. After reset and after every configuration write the block sizes and
// layer shares are recomputed by four bit-serial divisions and four multiply
// steps, and in_tready stays low during that setup.
`include "sparse_3d_block_owner_map_core_defines.svh"
module sparse_3d_block_owner_map_core #(
  parameter int INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // global_row, global_col
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // owner_layer, owner_grid_row, owner_grid_col,
                                  // local_row, local_col
);
  import sbom_pkg::*;

  localparam int IW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int PW = 2 * GRID_QB + IW;

  cfg_ctrl_t     ctrl;
  logic [IW-1:0] mper, mbase, nper, nbase, share_n, share_l, lbase_n, lbase_l;

  logic en, in_fire;

  logic               row_v, col_v, row_last, col_last;
  logic [GRID_QB-1:0] prow, pcol;
  logic [IW-1:0]      row_off, col_off;

  logic               b_valid_r;
  logic [IW-1:0]      b_x_r, b_other_r, b_dvs_r, b_base_r;
  logic [GRID_QB-1:0] b_prow_r, b_pcol_r;

  logic                lay_v;
  logic [LAYER_QB-1:0] lay_who;
  logic [IW-1:0]       lay_off;
  logic [PW-1:0]       lay_pay;
  logic [IW-1:0]       lay_other;

  logic                out_valid_r;
  logic [LAYER_QB-1:0] out_layer_r;
  logic [GRID_QB-1:0]  out_prow_r, out_pcol_r;
  logic [IW-1:0]       out_lrow_r, out_lcol_r;

  sbom_cfg #(.IW(IW)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .mper      (mper),
    .mbase     (mbase),
    .nper      (nper),
    .nbase     (nbase),
    .share_n   (share_n),
    .share_l   (share_l),
    .lbase_n   (lbase_n),
    .lbase_l   (lbase_l)
  );

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && !ctrl.busy;
  assign in_fire   = in_tvalid && in_tready;

  sbom_grid_div #(.IW(IW)) u_row_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_fire),
    .dividend  (in_tdata[IW-1:0]),
    .divisor   (mper),
    .qmax      (ctrl.qmax_row),
    .base_last (mbase),
    .out_valid (row_v),
    .out_who   (prow),
    .out_off   (row_off),
    .out_last  (row_last)
  );

  sbom_grid_div #(.IW(IW)) u_col_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_fire),
    .dividend  (in_tdata[32+IW-1:32]),
    .divisor   (nper),
    .qmax      (ctrl.qmax_col),
    .base_last (nbase),
    .out_valid (col_v),
    .out_who   (pcol),
    .out_off   (col_off),
    .out_last  (col_last)
  );

  // pick the dimension that is split across layers and its share
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= row_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prow_r  <= prow;
      b_pcol_r  <= pcol;
      b_x_r     <= ctrl.split_cols ? col_off : row_off;
      b_other_r <= ctrl.split_cols ? row_off : col_off;
      if (ctrl.split_cols ? col_last : row_last) begin
        b_dvs_r  <= share_l;
        b_base_r <= lbase_l;
      end else begin
        b_dvs_r  <= share_n;
        b_base_r <= lbase_n;
      end
    end
  end

  sbom_layer_div #(.IW(IW), .PW(PW)) u_layer_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .dividend  (b_x_r),
    .divisor   (b_dvs_r),
    .base_last (b_base_r),
    .in_pay    ({b_prow_r, b_pcol_r, b_other_r}),
    .qmax      (ctrl.qmax_layer),
    .out_valid (lay_v),
    .out_who   (lay_who),
    .out_off   (lay_off),
    .out_pay   (lay_pay)
  );

  assign lay_other = lay_pay[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lay_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_layer_r <= lay_who;
      out_prow_r  <= lay_pay[PW-1:PW-GRID_QB];
      out_pcol_r  <= lay_pay[IW+GRID_QB-1:IW];
      out_lrow_r  <= ctrl.split_cols ? lay_other : lay_off;
      out_lcol_r  <= ctrl.split_cols ? lay_off : lay_other;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {32'(out_lcol_r), 32'(out_lrow_r), out_pcol_r, out_prow_r, out_layer_r};

  `SBOM_ASSERT_IMP(a_lanes_aligned, clk, rst_n, 1'b1, row_v == col_v)
  `SBOM_ASSERT_NXT(a_setup_after_write, clk, rst_n, cfg_wr_en, !in_tready)
  `SBOM_ASSERT_IMP(a_layer_range, clk, rst_n, out_valid_r, out_layer_r <= ctrl.qmax_layer)
  `SBOM_ASSERT_IMP(a_grid_range, clk, rst_n, out_valid_r,
                   (out_prow_r <= ctrl.qmax_row) && (out_pcol_r <= ctrl.qmax_col))

endmodule
